@@ src/cmm_pkg.sv @@
`timescale 1ns / 1ps

package cmm_pkg;

  // Entry-count ceiling for whole-cache scans
  localparam int unsigned MAX_ENTRIES_DEF = 65536;

  localparam int CFG_LSL_W = 4;
  localparam int CFG_TEC_W = 17;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_LSL_W-1:0] LSL_RESET = 4'd6;
  localparam logic [CFG_TEC_W-1:0] TEC_RESET = 17'd1024;
  localparam logic [CFG_LSL_W-1:0] LSL_MIN   = 4'd2;
  localparam logic [CFG_LSL_W-1:0] LSL_MAX   = 4'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LSL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TEC = 8'd1;

  localparam logic [11:0] OFF_START = 12'h000;
  localparam logic [11:0] OFF_ADDR  = 12'h008;
  localparam logic [11:0] OFF_SIZE  = 12'h010;
  localparam logic [11:0] OFF_OPER  = 12'h018;

  localparam logic [7:0] BUS_BYTES = 8'd8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ADDR  = 3'd1,
    ST_BURST = 3'd2,
    ST_BE    = 3'd3,
    ST_CMD   = 3'd4,
    ST_RANGE = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WB    = 2'd1,
    CMD_INVAL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PIPE = 3'd1,
    PH_SCAN = 3'd2,
    PH_WB   = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OPN_NOP   = 2'd0,
    OPN_FLUSH = 2'd1,
    OPN_INVAL = 2'd2
  } opn_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] reg_offset;
    logic [63:0] write_data;
    logic        data_present;
    logic [7:0]  burst_len;
    logic        enables_present;
    logic [3:0]  enable_length;
    logic [7:0]  enable_bits;
    logic        pipeline_busy;
    logic        writeback_busy;
    logic        wbuf_ready;
    logic        target_dirty;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_data;
    st_t         resp_status;
    cmd_t        cmd_kind;
    logic        cmd_by_index;
    logic [63:0] cmd_target;
    logic [63:0] next_target;
    phase_t      seq_phase;
    logic        start_pending;
  } out_item_t;

  typedef struct packed {
    logic [CFG_LSL_W-1:0] line_size_log2;
    logic [CFG_TEC_W-1:0] tag_entry_count;
  } cfg_t;

  typedef struct packed {
    st_t status;
  } chk_t;

  // Pattern entries touched by lanes 0..7 when the pattern repeats every len entries
  function automatic logic [7:0] be_need_mask(input logic [3:0] len);
    logic [7:0] m;
    if (len >= 4'd8) begin
      m = 8'hFF;
    end else begin
      m = 8'((9'd1 << len) - 9'd1);
    end
    return m;
  endfunction

endpackage

@@ src/cmm_bus_check.sv @@
`timescale 1ns / 1ps

module cmm_bus_check import cmm_pkg::*; (
  input  in_item_t item,
  output chk_t     chk
);

  logic [7:0] need;

  assign need = be_need_mask(item.enable_length);

  // Check order: offset, burst, byte enables
  always_comb begin
    chk.status = ST_OK;
    if (!(item.reg_offset inside {OFF_START, OFF_ADDR, OFF_SIZE, OFF_OPER})) begin
      chk.status = ST_ADDR;
    end else if (!item.data_present || item.burst_len != BUS_BYTES) begin
      chk.status = ST_BURST;
    end else if (item.enables_present &&
                 (item.enable_length == 4'd0 || (item.enable_bits & need) != need)) begin
      chk.status = ST_BE;
    end
  end

endmodule

@@ src/cmm_seq.sv @@
`timescale 1ns / 1ps

module cmm_seq import cmm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  chk_t      chk,
  input  cfg_t      cfg,
  output out_item_t res
);

  localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = (ENTRY_W > CFG_TEC_W) ? ENTRY_W : CFG_TEC_W;
  localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_ENTRIES);

  logic [63:0]        base_r, base_nxt;
  logic [63:0]        size_r, size_nxt;
  opn_t               pend_op_r, pend_op_nxt;
  logic               start_r, start_nxt;
  phase_t             phase_r, phase_nxt;
  logic               whole_r, whole_nxt;
  opn_t               act_op_r, act_op_nxt;
  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  logic [63:0]        line_r, line_nxt;
  logic [63:0]        end_r, end_nxt;

  logic [CFG_LSL_W-1:0] lsl;
  logic [63:0]          lbytes, lmask;
  logic [CMP_W-1:0]     cnt, tec_ext;
  logic [64:0]          sum65, rnd65, step65;
  logic                 scan_done, is_flush;

  always_comb begin
    if (cfg.line_size_log2 < LSL_MIN) begin
      lsl = LSL_MIN;
    end else if (cfg.line_size_log2 > LSL_MAX) begin
      lsl = LSL_MAX;
    end else begin
      lsl = cfg.line_size_log2;
    end
    lbytes = 64'd1 << lsl;
    lmask  = lbytes - 64'd1;
    tec_ext = CMP_W'(cfg.tag_entry_count);
    if (tec_ext == '0) begin
      cnt = CMP_W'(1);
    end else if (tec_ext > MAX_CNT) begin
      cnt = MAX_CNT;
    end else begin
      cnt = tec_ext;
    end
  end

  assign sum65  = {1'b0, base_r} + {1'b0, size_r};
  // Carry out of the round-up means the aligned end passes 2^64
  assign rnd65  = {1'b0, sum65[63:0]} + {1'b0, lmask};
  assign step65 = {1'b0, line_r} + {1'b0, lbytes};
  assign scan_done = whole_r ? (CMP_W'(entry_r) >= cnt) : (line_r >= end_r);
  assign is_flush  = (act_op_r == OPN_FLUSH);

  always_comb begin
    base_nxt    = base_r;
    size_nxt    = size_r;
    pend_op_nxt = pend_op_r;
    start_nxt   = start_r;
    phase_nxt   = phase_r;
    whole_nxt   = whole_r;
    act_op_nxt  = act_op_r;
    entry_nxt   = entry_r;
    line_nxt    = line_r;
    end_nxt     = end_r;
    res         = '0;
    res.resp_status = ST_OK;
    res.cmd_kind    = CMD_NONE;

    if (fire) begin
      if (item.op == OP_TICK) begin
        case (phase_r)
          PH_PIPE: begin
            if (!item.pipeline_busy) begin
              phase_nxt = (act_op_r == OPN_NOP) ? PH_WB : PH_SCAN;
            end
          end
          PH_SCAN: begin
            if (scan_done || act_op_r == OPN_NOP) begin
              phase_nxt = PH_WB;
            end else if (!is_flush || item.wbuf_ready) begin
              if (!is_flush || item.target_dirty) begin
                res.cmd_kind     = is_flush ? CMD_WB : CMD_INVAL;
                res.cmd_by_index = whole_r;
                res.cmd_target   = whole_r ? 64'(entry_r) : line_r;
              end
              if (whole_r) begin
                entry_nxt = entry_r + ENTRY_W'(1);
              end else begin
                line_nxt = step65[64] ? end_r : step65[63:0];
              end
            end
          end
          PH_WB: begin
            if (!item.writeback_busy) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            start_nxt  = 1'b0;
            phase_nxt  = PH_IDLE;
            whole_nxt  = 1'b0;
            act_op_nxt = OPN_NOP;
            entry_nxt  = '0;
            line_nxt   = '0;
            end_nxt    = '0;
          end
          default: ;
        endcase
      end else if (chk.status != ST_OK) begin
        res.resp_status = chk.status;
      end else begin
        case (item.op)
          OP_READ: begin
            case (item.reg_offset)
              OFF_START: res.read_data = {63'd0, (phase_r != PH_IDLE) || start_r};
              OFF_ADDR:  res.read_data = base_r;
              OFF_SIZE:  res.read_data = size_r;
              default:   res.read_data = {62'd0, pend_op_r};
            endcase
          end
          OP_WRITE: begin
            case (item.reg_offset)
              OFF_START: begin
                if (item.write_data != 64'd0) begin
                  if (phase_r != PH_IDLE) begin
                    start_nxt = 1'b1;
                  end else if (size_r != 64'd0 && (sum65[64] || rnd65[64])) begin
                    res.resp_status = ST_RANGE;
                  end else begin
                    start_nxt  = 1'b1;
                    phase_nxt  = PH_PIPE;
                    whole_nxt  = (size_r == 64'd0);
                    act_op_nxt = pend_op_r;
                    entry_nxt  = '0;
                    line_nxt   = (size_r == 64'd0) ? 64'd0 : (base_r & ~lmask);
                    end_nxt    = (size_r == 64'd0) ? 64'd0 : (rnd65[63:0] & ~lmask);
                  end
                end else if (phase_r == PH_IDLE) begin
                  start_nxt = 1'b0;
                end
              end
              OFF_ADDR: base_nxt = item.write_data;
              OFF_SIZE: size_nxt = item.write_data;
              default: begin
                if (item.write_data == 64'd1) begin
                  pend_op_nxt = OPN_FLUSH;
                end else if (item.write_data == 64'd2) begin
                  pend_op_nxt = OPN_INVAL;
                end else begin
                  pend_op_nxt = OPN_NOP;
                end
              end
            endcase
          end
          default: res.resp_status = ST_CMD;
        endcase
      end
    end

    res.next_target   = whole_nxt ? 64'(entry_nxt) : line_nxt;
    res.seq_phase     = phase_nxt;
    res.start_pending = (phase_nxt != PH_IDLE) || start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      size_r    <= '0;
      pend_op_r <= OPN_NOP;
      start_r   <= 1'b0;
      phase_r   <= PH_IDLE;
      whole_r   <= 1'b0;
      act_op_r  <= OPN_NOP;
      entry_r   <= '0;
      line_r    <= '0;
      end_r     <= '0;
    end else begin
      base_r    <= base_nxt;
      size_r    <= size_nxt;
      pend_op_r <= pend_op_nxt;
      start_r   <= start_nxt;
      phase_r   <= phase_nxt;
      whole_r   <= whole_nxt;
      act_op_r  <= act_op_nxt;
      entry_r   <= entry_nxt;
      line_r    <= line_nxt;
      end_r     <= end_nxt;
    end
  end

endmodule

@@ src/cache_maintenance_mmio_controller_top.sv @@
`timescale 1ns / 1ps

// Cache-maintenance controller with four 64-bit registers (start, address, size,
// operation) reached through bus-access items, and clock-tick items that step the
// flush/invalidate sequence one line or tag entry per tick (a flush tick only when the
// write buffer is ready). Every item gives one result. The block takes one item per
// cycle: each item passes an input register, one pass of checking and sequencer
// logic, and a result register; the result register frees itself in the same cycle
// it is taken, and only a stalled result holds back the input side.
// line_size_log2 and tag_entry_count are read live; write them only while idle.
module cache_maintenance_mmio_controller_top import cmm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [11:0] reg_offset, [75:12] write_data, [76] data_present, [84:77] burst_len,
  // [85] enables_present, [89:86] enable_length, [97:90] enable_bits,
  // [98] pipeline_busy, [99] writeback_busy, [100] wbuf_ready, [101] target_dirty
  input  logic [103:0]         in_tdata,
  // [1:0] op
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [63:0] read_data, [66:64] resp_status, [67] cmd_by_index, [131:68] cmd_target,
  // [195:132] next_target, [198:196] seq_phase, [199] start_pending
  output logic [199:0]         out_tdata,
  // [1:0] cmd_kind
  output logic [1:0]           out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  in_item_t  in_item, item_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t res, res_r;
  logic      out_valid_r, out_valid_nxt;
  logic      in_fire, proc_fire;
  chk_t      chk;
  cfg_t      cfg_r, cfg_nxt;

  assign in_item.op              = op_t'(in_tuser);
  assign in_item.reg_offset      = in_tdata[11:0];
  assign in_item.write_data      = in_tdata[75:12];
  assign in_item.data_present    = in_tdata[76];
  assign in_item.burst_len       = in_tdata[84:77];
  assign in_item.enables_present = in_tdata[85];
  assign in_item.enable_length   = in_tdata[89:86];
  assign in_item.enable_bits     = in_tdata[97:90];
  assign in_item.pipeline_busy   = in_tdata[98];
  assign in_item.writeback_busy  = in_tdata[99];
  assign in_item.wbuf_ready      = in_tdata[100];
  assign in_item.target_dirty    = in_tdata[101];

  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = proc_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_LSL: cfg_nxt.line_size_log2  = cfg_data[CFG_LSL_W-1:0];
        CFG_IDX_TEC: cfg_nxt.tag_entry_count = cfg_data[CFG_TEC_W-1:0];
        default: ;
      endcase
    end
  end

  cmm_bus_check u_check (
    .item (item_r),
    .chk  (chk)
  );

  cmm_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proc_fire),
    .item  (item_r),
    .chk   (chk),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.line_size_log2  <= LSL_RESET;
      cfg_r.tag_entry_count <= TEC_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // Payload registers: load on transfer only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (proc_fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.cmd_kind;
  assign out_tdata  = {res_r.start_pending, res_r.seq_phase, res_r.next_target,
                       res_r.cmd_target, res_r.cmd_by_index, res_r.resp_status,
                       res_r.read_data};

  a_free_in_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  a_no_cmd_on_bus_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.resp_status != ST_OK |-> res_r.cmd_kind == CMD_NONE)
    else $error("maintenance command on a failed bus access");

  a_cmd_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.cmd_kind == CMD_NONE |->
      res_r.cmd_target == 64'd0 && !res_r.cmd_by_index)
    else $error("stale target with no command");

  a_busy_reads_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.seq_phase != PH_IDLE |-> res_r.start_pending)
    else $error("running sequence without start readback");

endmodule
